FILE: design/stepper_axis_position_controller_macros.svh
// Assertion helpers for the stepper axis position controller.
`ifndef STEPPER_AXIS_POSITION_CONTROLLER_MACROS_SVH
`define STEPPER_AXIS_POSITION_CONTROLLER_MACROS_SVH

// same-cycle implication
`define SAPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sapc assertion failed");

// next-cycle implication
`define SAPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sapc assertion failed");

`endif

FILE: design/sapc_pkg.sv
`timescale 1ns / 1ps

package sapc_pkg;

	localparam int unsigned PosW   = 32;
	localparam int unsigned FieldW = 32;

	typedef logic signed [PosW-1:0]   pos_t;
	typedef logic signed [FieldW-1:0] field_t;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_MOVE_REL = 3'd1,
		OP_MOVE_ABS = 3'd2,
		OP_HOME     = 3'd3,
		OP_STOP     = 3'd4,
		OP_ENABLE   = 3'd5,
		OP_DISABLE  = 3'd6,
		OP_ZERO     = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_DISABLED = 3'd0,
		ST_IDLE     = 3'd1,
		ST_MOVING   = 3'd2,
		ST_TOP      = 3'd3,
		ST_BOTTOM   = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		CFG_SWITCHES_ACTIVE_LOW = 1'b0,
		CFG_DIRECTION_INVERTED  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		op_t    op;
		field_t amount;
		logic   home_upward;
		logic   top_switch_level;
		logic   bottom_switch_level;
		logic   step_due;
	} cmd_t;

	typedef struct packed {
		logic       step_pulse;
		logic       dir_pin;
		logic       driver_enabled;
		logic [2:0] status;
		field_t     position;
		field_t     target;
	} res_t;

	typedef struct packed {
		pos_t    position_count;
		pos_t    target_count;
		logic    homing_active;
		logic    homing_up;
		logic    moving_up;
		logic    enabled_flag;
		status_t status_code;
	} state_t;

endpackage

FILE: design/sapc_if.sv
`timescale 1ns / 1ps

interface sapc_cmd_if;
	logic            valid;
	logic            ready;
	sapc_pkg::cmd_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface sapc_res_if;
	logic            valid;
	logic            ready;
	sapc_pkg::res_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: design/sapc_step.sv
`timescale 1ns / 1ps

module sapc_step (
	input  sapc_pkg::state_t cur,
	input  sapc_pkg::cmd_t   cmd,
	input  logic             switches_active_low,
	output sapc_pkg::state_t nxt,
	output logic             step_pulse
);

	sapc_pkg::pos_t amt;
	sapc_pkg::pos_t mv_tgt;
	sapc_pkg::pos_t pos_step;
	logic           top_p;
	logic           bot_p;
	logic           mv_up;
	logic           mv_blk;
	logic           hu_blk;
	logic           hm_blk;
	logic           tk_up;
	logic           tk_blk;
	logic           at_tgt;
	logic           active;
	logic           step_up;

	assign amt    = sapc_pkg::pos_t'(cmd.amount);
	assign top_p  = switches_active_low ? !cmd.top_switch_level : cmd.top_switch_level;
	assign bot_p  = switches_active_low ? !cmd.bottom_switch_level : cmd.bottom_switch_level;
	assign mv_tgt = (cmd.op == sapc_pkg::OP_MOVE_REL) ? cur.position_count + amt : amt;
	assign mv_up  = mv_tgt > cur.position_count;
	assign mv_blk = mv_up ? top_p : bot_p;
	assign hu_blk = cmd.home_upward ? top_p : bot_p;
	assign hm_blk = cur.homing_up ? top_p : bot_p;
	assign tk_up  = cur.target_count > cur.position_count;
	assign tk_blk = tk_up ? top_p : bot_p;
	assign at_tgt = cur.position_count == cur.target_count;
	assign active = cur.homing_active || (cur.status_code == sapc_pkg::ST_MOVING && !at_tgt);
	assign step_up  = cur.homing_active ? cur.homing_up : tk_up;
	assign pos_step = step_up ? cur.position_count + sapc_pkg::pos_t'(1)
	                          : cur.position_count - sapc_pkg::pos_t'(1);

	always_comb begin
		nxt        = cur;
		step_pulse = 1'b0;
		unique case (cmd.op)
			sapc_pkg::OP_TICK: begin
				if (!cur.enabled_flag) begin
					nxt.status_code = sapc_pkg::ST_DISABLED;
				end else if (active && top_p && cur.moving_up) begin
					nxt.homing_active = 1'b0;
					nxt.target_count  = cur.position_count;
					if (cur.homing_up) begin
						nxt.position_count = '0;
						nxt.target_count   = '0;
					end
					nxt.status_code = sapc_pkg::ST_TOP;
				end else if (active && bot_p && !cur.moving_up) begin
					nxt.homing_active = 1'b0;
					nxt.target_count  = cur.position_count;
					if (!cur.homing_up) begin
						nxt.position_count = '0;
						nxt.target_count   = '0;
					end
					nxt.status_code = sapc_pkg::ST_BOTTOM;
				end else if (cur.homing_active && hm_blk) begin
					nxt.homing_active  = 1'b0;
					nxt.position_count = '0;
					nxt.target_count   = '0;
					nxt.status_code    = cur.homing_up ? sapc_pkg::ST_TOP : sapc_pkg::ST_BOTTOM;
				end else if (!cur.homing_active && at_tgt) begin
					nxt.status_code = sapc_pkg::ST_IDLE;
				end else if (!cur.homing_active && tk_blk) begin
					nxt.target_count = cur.position_count;
					nxt.status_code  = tk_up ? sapc_pkg::ST_TOP : sapc_pkg::ST_BOTTOM;
				end else begin
					nxt.moving_up   = step_up;
					nxt.status_code = sapc_pkg::ST_MOVING;
					if (cmd.step_due) begin
						nxt.position_count = pos_step;
						step_pulse         = 1'b1;
					end
				end
			end
			sapc_pkg::OP_MOVE_REL, sapc_pkg::OP_MOVE_ABS: begin
				if (cmd.op == sapc_pkg::OP_MOVE_ABS || amt != '0) begin
					nxt.homing_active = 1'b0;
					nxt.enabled_flag  = 1'b1;
					if (cmd.op == sapc_pkg::OP_MOVE_ABS && amt == cur.position_count) begin
						nxt.target_count = amt;
						nxt.status_code  = sapc_pkg::ST_IDLE;
					end else begin
						nxt.moving_up = mv_up;
						if (mv_blk) begin
							nxt.target_count = cur.position_count;
							nxt.status_code  = mv_up ? sapc_pkg::ST_TOP : sapc_pkg::ST_BOTTOM;
						end else begin
							nxt.target_count = mv_tgt;
							nxt.status_code  = sapc_pkg::ST_MOVING;
						end
					end
				end
			end
			sapc_pkg::OP_HOME: begin
				nxt.homing_up    = cmd.home_upward;
				nxt.moving_up    = cmd.home_upward;
				nxt.enabled_flag = 1'b1;
				nxt.target_count = cur.position_count;
				if (hu_blk) begin
					nxt.homing_active  = 1'b0;
					nxt.position_count = '0;
					nxt.target_count   = '0;
					nxt.status_code    = cmd.home_upward ? sapc_pkg::ST_TOP : sapc_pkg::ST_BOTTOM;
				end else begin
					nxt.homing_active = 1'b1;
					nxt.status_code   = sapc_pkg::ST_MOVING;
				end
			end
			sapc_pkg::OP_STOP: begin
				nxt.target_count  = cur.position_count;
				nxt.homing_active = 1'b0;
				if (cur.enabled_flag) begin
					nxt.status_code = sapc_pkg::ST_IDLE;
				end
			end
			sapc_pkg::OP_ENABLE: begin
				nxt.enabled_flag = 1'b1;
				nxt.status_code  = sapc_pkg::ST_IDLE;
			end
			sapc_pkg::OP_DISABLE: begin
				nxt.enabled_flag  = 1'b0;
				nxt.homing_active = 1'b0;
				nxt.status_code   = sapc_pkg::ST_DISABLED;
			end
			sapc_pkg::OP_ZERO: begin
				nxt.position_count = '0;
				nxt.target_count   = '0;
			end
		endcase
	end

endmodule

FILE: design/stepper_axis_position_controller.sv
`timescale 1ns / 1ps

// Single stepper axis position controller.
// cmd: one transaction per tick or command (op, amount, home_upward, raw switch
//   levels, step_due). res: one transaction per cmd transaction, in order, with
//   step_pulse, dir_pin, driver_enabled, status and the position and target left
//   after that item.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx (switch polarity,
//   direction inversion) at the clock edge; write only while no item is in flight.
// Path: a cmd transaction is captured in the input register, evaluated by the step
//   logic and registered into the result register that drives res when res is free.
// Throughput: one item per cycle unless res is held off; the step logic is a single
//   compare/increment/mux layer between the input register and axis state/result registers.
// Stall: while res is held off, the result register keeps its transaction, the input
//   register takes one more item, and cmd.ready drops until res drains.
// Reset (arst_n low): position and target zero, homing off, directions up, driver
//   disabled, status disabled, switches active low, direction not inverted, both
//   pipeline registers empty.
module stepper_axis_position_controller (
	input  logic               clk,
	input  logic               arst_n,
	sapc_cmd_if.sink           cmd,
	sapc_res_if.source         res,
	input  logic               cfg_we,
	input  sapc_pkg::cfg_idx_t cfg_idx,
	input  logic [0:0]         cfg_wdata
);

	sapc_pkg::cmd_t   cmd_s1;
	logic             vld_s1;
	sapc_pkg::state_t state_q;
	sapc_pkg::state_t state_nxt;
	logic             pulse_nxt;
	logic             sw_low_q;
	logic             dir_inv_q;
	sapc_pkg::res_t   res_q;
	logic             res_vld_q;
	logic             adv;

	assign adv       = vld_s1 && (!res_vld_q || res.ready);
	assign cmd.ready = !vld_s1 || adv;
	assign res.valid = res_vld_q;
	assign res.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_low_q  <= 1'b1;
			dir_inv_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sapc_pkg::CFG_SWITCHES_ACTIVE_LOW: sw_low_q  <= cfg_wdata[0];
				sapc_pkg::CFG_DIRECTION_INVERTED:  dir_inv_q <= cfg_wdata[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
		end else if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
	end

	sapc_step u_step (
		.cur                 (state_q),
		.cmd                 (cmd_s1),
		.switches_active_low (sw_low_q),
		.nxt                 (state_nxt),
		.step_pulse          (pulse_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.position_count <= '0;
			state_q.target_count   <= '0;
			state_q.homing_active  <= 1'b0;
			state_q.homing_up      <= 1'b1;
			state_q.moving_up      <= 1'b1;
			state_q.enabled_flag   <= 1'b0;
			state_q.status_code    <= sapc_pkg::ST_DISABLED;
			res_vld_q              <= 1'b0;
		end else begin
			if (adv) begin
				state_q <= state_nxt;
			end
			if (adv) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.step_pulse     <= pulse_nxt;
			res_q.dir_pin        <= state_nxt.moving_up ^ dir_inv_q;
			res_q.driver_enabled <= state_nxt.enabled_flag;
			res_q.status         <= state_nxt.status_code;
			res_q.position       <= sapc_pkg::FieldW'(state_nxt.position_count);
			res_q.target         <= sapc_pkg::FieldW'(state_nxt.target_count);
		end
	end

endmodule

FILE: design/sapc_checker.sv
`timescale 1ns / 1ps
`include "stepper_axis_position_controller_macros.svh"

module sapc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_ready,
	input sapc_pkg::res_t res_data
);

	`SAPC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_data))
	`SAPC_ASSERT_NOW(a_pulse_moving, clk, arst_n, res_valid && res_data.step_pulse, res_data.driver_enabled && res_data.status == sapc_pkg::ST_MOVING)
	`SAPC_ASSERT_NOW(a_enable_status, clk, arst_n, res_valid, res_data.driver_enabled == (res_data.status != sapc_pkg::ST_DISABLED))

endmodule

bind stepper_axis_position_controller sapc_checker u_sapc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);

FILE: bench/sapc_axis_check.sv
`timescale 1ns / 1ps

module sapc_axis_check (
	input  logic               clk,
	input  logic               arst_n,
	sapc_cmd_if                cmd,
	sapc_res_if                res,
	input  logic               cfg_we,
	input  sapc_pkg::cfg_idx_t cfg_idx,
	input  logic [0:0]         cfg_wdata,
	output int unsigned        fail_count
);
	import sapc_pkg::*;

	pos_t    axis_pos;
	pos_t    axis_tgt;
	logic    homing;
	logic    home_up;
	logic    going_up;
	logic    drv_en;
	status_t axis_st;
	logic    sw_low;
	logic    dir_inv;
	logic    top_hit;
	logic    bot_hit;

	res_t        awaited_q[$];
	res_t        want_r;
	res_t        got_r;
	int unsigned mismatches;
	int unsigned outstanding;

	assign fail_count = mismatches + outstanding;

	function automatic logic blocked(logic up);
		return up ? top_hit : bot_hit;
	endfunction

	function automatic status_t limit_of(logic up);
		return up ? ST_TOP : ST_BOTTOM;
	endfunction

	function automatic void stop_axis();
		axis_tgt = axis_pos;
		homing = 1'b0;
		if (drv_en) begin
			axis_st = ST_IDLE;
		end
	endfunction

	function automatic void clear_pos();
		axis_pos = '0;
		axis_tgt = '0;
	endfunction

	function automatic void power_up();
		drv_en = 1'b1;
		axis_st = ST_IDLE;
	endfunction

	function automatic void begin_travel();
		logic up;
		up = axis_tgt > axis_pos;
		going_up = up;
		if (blocked(up)) begin
			stop_axis();
			axis_st = limit_of(up);
		end else begin
			axis_st = ST_MOVING;
		end
	endfunction

	function automatic logic step_toward(logic up, logic due);
		going_up = up;
		if (blocked(up)) begin
			stop_axis();
			axis_st = limit_of(up);
			return 1'b0;
		end
		if (!due) begin
			return 1'b0;
		end
		axis_pos = up ? axis_pos + pos_t'(1) : axis_pos - pos_t'(1);
		return 1'b1;
	endfunction

	function automatic logic run_tick(logic due);
		logic active;
		logic pulse;
		logic up;
		if (!drv_en) begin
			axis_st = ST_DISABLED;
			return 1'b0;
		end
		active = homing || (axis_st == ST_MOVING && axis_pos != axis_tgt);
		if (active && top_hit && going_up) begin
			stop_axis();
			if (home_up) begin
				clear_pos();
			end
			axis_st = ST_TOP;
			return 1'b0;
		end
		if (active && bot_hit && !going_up) begin
			stop_axis();
			if (!home_up) begin
				clear_pos();
			end
			axis_st = ST_BOTTOM;
			return 1'b0;
		end
		if (homing) begin
			if (blocked(home_up)) begin
				stop_axis();
				clear_pos();
				axis_st = limit_of(home_up);
				return 1'b0;
			end
			pulse = step_toward(home_up, due);
			axis_st = ST_MOVING;
			return pulse;
		end
		if (axis_pos == axis_tgt) begin
			axis_st = ST_IDLE;
			return 1'b0;
		end
		up = axis_tgt > axis_pos;
		if (blocked(up)) begin
			stop_axis();
			axis_st = limit_of(up);
			return 1'b0;
		end
		pulse = step_toward(up, due);
		axis_st = ST_MOVING;
		return pulse;
	endfunction

	function automatic res_t advance_axis(cmd_t c);
		res_t r;
		pos_t amt;
		logic pulse;
		amt = pos_t'(c.amount);
		pulse = 1'b0;
		top_hit = sw_low ? !c.top_switch_level : c.top_switch_level;
		bot_hit = sw_low ? !c.bottom_switch_level : c.bottom_switch_level;
		case (c.op)
			OP_TICK: begin
				pulse = run_tick(c.step_due);
			end
			OP_MOVE_REL: begin
				if (amt != '0) begin
					homing = 1'b0;
					axis_tgt = axis_pos + amt;
					if (!drv_en) begin
						power_up();
					end
					begin_travel();
				end
			end
			OP_MOVE_ABS: begin
				homing = 1'b0;
				axis_tgt = amt;
				if (!drv_en) begin
					power_up();
				end
				if (axis_pos == axis_tgt) begin
					axis_st = ST_IDLE;
				end else begin
					begin_travel();
				end
			end
			OP_HOME: begin
				home_up = c.home_upward;
				homing = 1'b1;
				axis_tgt = axis_pos;
				if (!drv_en) begin
					power_up();
				end
				going_up = home_up;
				if (blocked(home_up)) begin
					stop_axis();
					clear_pos();
					axis_st = limit_of(home_up);
				end else begin
					axis_st = ST_MOVING;
				end
			end
			OP_STOP: begin
				stop_axis();
			end
			OP_ENABLE: begin
				power_up();
			end
			OP_DISABLE: begin
				drv_en = 1'b0;
				homing = 1'b0;
				axis_st = ST_DISABLED;
			end
			default: begin
				clear_pos();
			end
		endcase
		r.step_pulse = pulse;
		r.dir_pin = going_up ^ dir_inv;
		r.driver_enabled = drv_en;
		r.status = axis_st;
		r.position = field_t'(axis_pos);
		r.target = field_t'(axis_tgt);
		return r;
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_pos = '0;
			axis_tgt = '0;
			homing = 1'b0;
			home_up = 1'b1;
			going_up = 1'b1;
			drv_en = 1'b0;
			axis_st = ST_DISABLED;
			sw_low = 1'b1;
			dir_inv = 1'b0;
			top_hit = 1'b0;
			bot_hit = 1'b0;
			awaited_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_SWITCHES_ACTIVE_LOW: sw_low = cfg_wdata[0];
					CFG_DIRECTION_INVERTED:  dir_inv = cfg_wdata[0];
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready) begin
				awaited_q.push_back(advance_axis(cmd.data));
				outstanding++;
			end
			if (res.valid && res.ready) begin
				if (awaited_q.size() == 0) begin
					$error("result transaction with no item pending");
					mismatches++;
				end else begin
					want_r = awaited_q.pop_front();
					outstanding--;
					got_r = res.data;
					check_field("step_pulse", want_r.step_pulse, got_r.step_pulse);
					check_field("dir_pin", want_r.dir_pin, got_r.dir_pin);
					check_field("driver_enabled", want_r.driver_enabled, got_r.driver_enabled);
					check_field("status", want_r.status, got_r.status);
					check_field("position", want_r.position, got_r.position);
					check_field("target", want_r.target, got_r.target);
				end
			end
		end
	end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import sapc_pkg::*;

	localparam int unsigned ITEMS_PER_PHASE = 125;
	localparam int unsigned CYCLE_LIMIT     = 500000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	cfg_idx_t   cfg_idx;
	logic [0:0] cfg_wdata;

	int unsigned failures;
	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned cycle_count;
	logic        sw_low_now;
	logic        steady;

	sapc_cmd_if cmd_ch ();
	sapc_res_if res_ch ();

	stepper_axis_position_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	sapc_axis_check axis_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.res        (res_ch),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.fail_count (failures)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial results_seen = 0;
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) begin
			results_seen <= results_seen + 1;
		end
	end

	// result back-pressure: short and long stalls, plus long open stretches
	initial begin
		int unsigned r;
		int unsigned len;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				res_ch.ready <= 1'b1;
				len = $urandom_range(1, 8);
			end else if (r < 62) begin
				res_ch.ready <= 1'b1;
				len = $urandom_range(30, 80);
			end else if (r < 92) begin
				res_ch.ready <= 1'b0;
				len = $urandom_range(1, 3);
			end else begin
				res_ch.ready <= 1'b0;
				len = $urandom_range(10, 40);
			end
			repeat (len) @(posedge clk);
		end
	end

	// pressed state is translated to a pin level under the current polarity
	function automatic cmd_t make_cmd(op_t op, field_t amount, logic home_up,
			logic top_p, logic bot_p, logic due);
		cmd_t c;
		c.op = op;
		c.amount = amount;
		c.home_upward = home_up;
		c.top_switch_level = top_p ^ sw_low_now;
		c.bottom_switch_level = bot_p ^ sw_low_now;
		c.step_due = due;
		return c;
	endfunction

	function automatic cmd_t random_cmd();
		int unsigned r;
		int unsigned a;
		op_t    op;
		field_t amt;
		r = $urandom_range(0, 99);
		if (r < 60) op = OP_TICK;
		else if (r < 70) op = OP_MOVE_REL;
		else if (r < 78) op = OP_MOVE_ABS;
		else if (r < 85) op = OP_HOME;
		else if (r < 89) op = OP_STOP;
		else if (r < 93) op = OP_ENABLE;
		else if (r < 96) op = OP_DISABLE;
		else op = OP_ZERO;
		a = $urandom_range(0, 99);
		amt = field_t'($urandom);
		if (op == OP_MOVE_REL) begin
			if (a < 6) amt = '0;
			else if (a < 80) amt = field_t'(int'($urandom_range(0, 60)) - 30);
			else if (a > 94) begin
				case ($urandom_range(0, 3))
					0: amt = 32'h7fffffff;
					1: amt = 32'h80000000;
					2: amt = 32'hffffffff;
					default: amt = 32'h00000001;
				endcase
			end
		end else if (op == OP_MOVE_ABS && a < 85) begin
			amt = field_t'(int'($urandom_range(0, 80)) - 40);
		end
		return make_cmd(op, amt, 1'($urandom_range(0, 1)),
			$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
			$urandom_range(0, 4) != 0);
	endfunction

	task automatic send_item(cmd_t c);
		int unsigned gap;
		int unsigned r;
		gap = 0;
		if (!steady) begin
			r = $urandom_range(0, 99);
			if (r >= 92) gap = $urandom_range(8, 40);
			else if (r >= 55) gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(logic sal, logic dinv);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_SWITCHES_ACTIVE_LOW;
		cfg_wdata <= sal;
		@(posedge clk);
		cfg_idx <= CFG_DIRECTION_INVERTED;
		cfg_wdata <= dinv;
		@(posedge clk);
		cfg_we <= 1'b0;
		sw_low_now = sal;
	endtask

	task automatic run_directed();
		send_item(make_cmd(OP_TICK, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_MOVE_REL, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_ENABLE, 32'hffffffff, 1'b1, 1'b0, 1'b0, 1'b0));
		send_item(make_cmd(OP_MOVE_REL, 32'd3, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_TICK, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0));
		repeat (4) send_item(make_cmd(OP_TICK, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_MOVE_ABS, 32'h7fffffff, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_TICK, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_MOVE_ABS, 32'h80000000, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_TICK, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_MOVE_REL, 32'h7fffffff, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_STOP, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1));
		// homing: one step up, then the top switch closes
		send_item(make_cmd(OP_HOME, 32'h0, 1'b1, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_TICK, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_TICK, 32'h0, 1'b0, 1'b1, 1'b0, 1'b1));
		// homing down with the bottom switch already closed
		send_item(make_cmd(OP_HOME, 32'h0, 1'b0, 1'b0, 1'b1, 1'b1));
		// limits during plain moves, on and off the homing side
		send_item(make_cmd(OP_MOVE_REL, 32'd5, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_TICK, 32'h0, 1'b0, 1'b1, 1'b0, 1'b1));
		send_item(make_cmd(OP_MOVE_REL, -32'sd4, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_TICK, 32'h0, 1'b0, 1'b0, 1'b1, 1'b1));
		send_item(make_cmd(OP_ZERO, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_DISABLE, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_MOVE_ABS, 32'd7, 1'b0, 1'b0, 1'b0, 1'b1));
		send_item(make_cmd(OP_DISABLE, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1));
	endtask

	initial begin
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_SWITCHES_ACTIVE_LOW;
		cfg_wdata <= 1'b0;
		arst_n = 1'b0;
		items_sent = 0;
		sw_low_now = 1'b1;
		steady = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 4; phase++) begin
			if (phase > 0) begin
				drain();
			end
			set_config(!phase[0], phase[0] ^ phase[1]);
			if (phase == 0) begin
				run_directed();
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i % 64 == 0) begin
					steady = ($urandom_range(0, 3) == 0);
				end
				send_item(random_cmd());
			end
		end
		drain();
		repeat (10) @(posedge clk);
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
